// ----- rtl/bsc_pkg.sv -----
`default_nettype none

package bsc_pkg;

  // Sizing of the tables
  localparam int MAX_PROCESSES = 16;
  localparam int MAX_RESOURCES = 8;
  localparam int AMOUNT_WIDTH  = 16;

  // Derived widths
  localparam int PROC_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int RES_W  = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int PCNT_W = $clog2(MAX_PROCESSES + 1);
  localparam int RCNT_W = $clog2(MAX_RESOURCES + 1);
  localparam int WORK_W = AMOUNT_WIDTH + PCNT_W;
  localparam int SUM_W  = WORK_W + 1;
  localparam int ADDR_W = PROC_W + RES_W;
  localparam int DEPTH  = 2 ** ADDR_W;

  // Fixed field widths of the channels
  localparam int KIND_W     = 2;
  localparam int PIDX_W     = 4;
  localparam int RIDX_W     = 3;
  localparam int AMT_IN_W   = 16;
  localparam int GPROC_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int NP_REG_W   = 5;
  localparam int NR_REG_W   = 4;

  typedef logic [AMOUNT_WIDTH-1:0] amt_t;
  typedef logic [WORK_W-1:0]       work_t;
  typedef logic [ADDR_W-1:0]       addr_t;
  typedef logic [MAX_RESOURCES-1:0][AMOUNT_WIDTH-1:0] avail_vec_t;

  // Transaction kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_ALLOC = 2'd0,
    KIND_LOAD_MAX   = 2'd1,
    KIND_LOAD_AVAIL = 2'd2,
    KIND_START      = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_PROCESSES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_RESOURCES = 2'd1;

  // Table write request
  typedef struct packed {
    logic  alloc_we;
    logic  max_we;
    logic  avail_we;
    addr_t addr;
    logic [RES_W-1:0] res;
    amt_t  data;
  } mem_wr_t;

  // Shared adder / comparator result
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             over;
  } alu_res_t;

  // Zero counts as one, anything above the maximum as the maximum
  function automatic logic [PCNT_W-1:0] clamp_np(input logic [NP_REG_W-1:0] v);
    logic [PCNT_W-1:0] r;
    if (v == '0) r = PCNT_W'(1);
    else if (int'(v) > MAX_PROCESSES) r = PCNT_W'(MAX_PROCESSES);
    else r = PCNT_W'(v);
    return r;
  endfunction

  function automatic logic [RCNT_W-1:0] clamp_nr(input logic [NR_REG_W-1:0] v);
    logic [RCNT_W-1:0] r;
    if (v == '0) r = RCNT_W'(1);
    else if (int'(v) > MAX_RESOURCES) r = RCNT_W'(MAX_RESOURCES);
    else r = RCNT_W'(v);
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bsc_if.sv -----
`default_nettype none

// Input channel: load and start transactions
interface bsc_in_if;
  import bsc_pkg::*;
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [PIDX_W-1:0]   process_index;
  logic [RIDX_W-1:0]   resource_index;
  logic [AMT_IN_W-1:0] amount;

  modport source (output valid, kind, process_index, resource_index, amount, input ready);
  modport sink   (input valid, kind, process_index, resource_index, amount, output ready);
endinterface

// Result channel: one transaction per grant, or a single empty one if nothing is granted
interface bsc_out_if;
  import bsc_pkg::*;
  logic               valid;
  logic               ready;
  logic [GPROC_W-1:0] granted_process;
  logic               has_process;
  logic               is_safe;
  logic               last;

  modport source (output valid, granted_process, has_process, is_safe, last, input ready);
  modport sink   (input valid, granted_process, has_process, is_safe, last, output ready);
endinterface

// Configuration write channel
interface bsc_cfg_if;
  import bsc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bsc_mem.sv -----
`default_nettype none

module bsc_mem (
  input  wire                       clk,
  input  wire bsc_pkg::mem_wr_t     wr,
  input  wire bsc_pkg::addr_t       rd_addr,
  output bsc_pkg::amt_t             rd_alloc,
  output bsc_pkg::amt_t             rd_max,
  output bsc_pkg::avail_vec_t       avail
);
  import bsc_pkg::*;

  amt_t alloc_mem [DEPTH];
  amt_t max_mem   [DEPTH];
  avail_vec_t avail_r;

  // Allocation table, registered read
  always_ff @(posedge clk) begin
    if (wr.alloc_we) begin
      alloc_mem[wr.addr] <= wr.data;
    end
    rd_alloc <= alloc_mem[rd_addr];
  end

  // Maximum-claim table, registered read
  always_ff @(posedge clk) begin
    if (wr.max_we) begin
      max_mem[wr.addr] <= wr.data;
    end
    rd_max <= max_mem[rd_addr];
  end

  // Loaded available vector
  always_ff @(posedge clk) begin
    if (wr.avail_we) begin
      avail_r[wr.res] <= wr.data;
    end
  end

  assign avail = avail_r;

endmodule

`default_nettype wire

// ----- rtl/bsc_alu.sv -----
`default_nettype none

module bsc_alu (
  input  wire bsc_pkg::amt_t     alloc,
  input  wire bsc_pkg::amt_t     max_claim,
  input  wire bsc_pkg::work_t    work,
  output bsc_pkg::alu_res_t      res
);
  import bsc_pkg::*;

  // need > work  <=>  max > alloc + work; the same sum feeds the release step
  always_comb begin
    res.sum  = SUM_W'(alloc) + SUM_W'(work);
    res.over = SUM_W'(max_claim) > res.sum;
  end

endmodule

`default_nettype wire

// ----- rtl/bankers_safety_check.sv -----
`default_nettype none

// Load transactions: accepted one per cycle while the sequencer is idle, no result.
// Start transaction: the single shared adder/comparator walks the tables one
// element at a time (registered RAM read, then compare or add) over np passes
// of np processes and nr resources each; the check takes longer if the
// result channel stalls. Input is not ready until the check has finished.
// Reset (synchronous, rst_n low): sequencer idle, no result held, registers 16 / 8.
module bankers_safety_check (
  input  wire          clk,
  input  wire          rst_n,
  bsc_in_if.sink       in_chan,
  bsc_out_if.source    out_chan,
  bsc_cfg_if.sink      cfg_chan
);
  import bsc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_INIT    = 9'b000000010,
    S_PROC    = 9'b000000100,
    S_CHK_RD  = 9'b000001000,
    S_CHK_CMP = 9'b000010000,
    S_ADD_RD  = 9'b000100000,
    S_ADD_WR  = 9'b001000000,
    S_GRANT   = 9'b010000000,
    S_FIN     = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   next_proc;

  logic [PCNT_W-1:0] np_r, np_nxt;
  logic [RCNT_W-1:0] nr_r, nr_nxt;
  logic [PCNT_W-1:0] pass_r, pass_nxt;
  logic [PROC_W-1:0] proc_r, proc_nxt;
  logic [RES_W-1:0]  res_r, res_nxt;
  logic [PCNT_W-1:0] gcnt_r, gcnt_nxt;
  logic [MAX_PROCESSES-1:0] fin_r, fin_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [PROC_W-1:0] pend_proc_r, pend_proc_nxt;

  logic               out_valid_r;
  logic [GPROC_W-1:0] out_proc_r;
  logic               out_has_r, out_safe_r, out_last_r;

  logic               push_v;
  logic [GPROC_W-1:0] push_proc;
  logic               push_has, push_safe, push_last;

  work_t      work_r [MAX_RESOURCES];
  logic       work_we;
  mem_wr_t    mem_wr;
  addr_t      rd_addr;
  amt_t       rd_alloc, rd_max;
  avail_vec_t avail;
  alu_res_t   alu;

  logic in_acc, cfg_acc, slot_free, last_res, last_proc, last_pass;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign cfg_acc   = cfg_chan.valid && cfg_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign last_res  = RCNT_W'(res_r) == (nr_r - RCNT_W'(1));
  assign last_proc = PCNT_W'(proc_r) == (np_r - PCNT_W'(1));
  assign last_pass = pass_r == (np_r - PCNT_W'(1));

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  // Table writes from load transactions; out-of-range loads dropped
  always_comb begin
    mem_wr.addr     = {PROC_W'(in_chan.process_index), RES_W'(in_chan.resource_index)};
    mem_wr.res      = RES_W'(in_chan.resource_index);
    mem_wr.data     = AMOUNT_WIDTH'(in_chan.amount);
    mem_wr.alloc_we = 1'b0;
    mem_wr.max_we   = 1'b0;
    mem_wr.avail_we = 1'b0;
    if (in_acc && int'(in_chan.resource_index) < MAX_RESOURCES) begin
      mem_wr.avail_we = (in_chan.kind == KIND_LOAD_AVAIL);
      if (int'(in_chan.process_index) < MAX_PROCESSES) begin
        mem_wr.alloc_we = (in_chan.kind == KIND_LOAD_ALLOC);
        mem_wr.max_we   = (in_chan.kind == KIND_LOAD_MAX);
      end
    end
  end

  assign rd_addr = {proc_r, res_r};

  bsc_mem u_mem (
    .clk      (clk),
    .wr       (mem_wr),
    .rd_addr  (rd_addr),
    .rd_alloc (rd_alloc),
    .rd_max   (rd_max),
    .avail    (avail)
  );

  bsc_alu u_alu (
    .alloc     (rd_alloc),
    .max_claim (rd_max),
    .work      (work_r[res_r]),
    .res       (alu)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    np_nxt        = np_r;
    nr_nxt        = nr_r;
    pass_nxt      = pass_r;
    proc_nxt      = proc_r;
    res_nxt       = res_r;
    gcnt_nxt      = gcnt_r;
    fin_nxt       = fin_r;
    pend_v_nxt    = pend_v_r;
    pend_proc_nxt = pend_proc_r;
    push_v        = 1'b0;
    push_proc     = GPROC_W'(pend_proc_r);
    push_has      = 1'b1;
    push_safe     = 1'b0;
    push_last     = 1'b0;
    work_we       = 1'b0;
    next_proc     = 1'b0;

    if (cfg_acc) begin
      case (cfg_chan.index)
        CFG_NUM_PROCESSES: np_nxt = clamp_np(NP_REG_W'(cfg_chan.data));
        CFG_NUM_RESOURCES: nr_nxt = clamp_nr(NR_REG_W'(cfg_chan.data));
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_chan.kind == KIND_START) state_nxt = S_INIT;
      end
      S_INIT: begin
        pass_nxt   = '0;
        proc_nxt   = '0;
        gcnt_nxt   = '0;
        fin_nxt    = '0;
        pend_v_nxt = 1'b0;
        state_nxt  = S_PROC;
      end
      S_PROC: begin
        res_nxt = '0;
        if (fin_r[proc_r]) next_proc = 1'b1;
        else state_nxt = S_CHK_RD;
      end
      S_CHK_RD: state_nxt = S_CHK_CMP;
      S_CHK_CMP: begin
        if (alu.over) begin
          next_proc = 1'b1;
        end else if (last_res) begin
          res_nxt   = '0;
          state_nxt = S_ADD_RD;
        end else begin
          res_nxt   = res_r + RES_W'(1);
          state_nxt = S_CHK_RD;
        end
      end
      S_ADD_RD: state_nxt = S_ADD_WR;
      S_ADD_WR: begin
        work_we = 1'b1;
        if (last_res) begin
          state_nxt = S_GRANT;
        end else begin
          res_nxt   = res_r + RES_W'(1);
          state_nxt = S_ADD_RD;
        end
      end
      S_GRANT: begin
        // previous grant goes out only now that it is known not to be the last
        if (!pend_v_r || slot_free) begin
          push_v          = pend_v_r;
          pend_proc_nxt   = proc_r;
          pend_v_nxt      = 1'b1;
          fin_nxt[proc_r] = 1'b1;
          gcnt_nxt        = gcnt_r + PCNT_W'(1);
          next_proc       = 1'b1;
        end
      end
      S_FIN: begin
        if (slot_free) begin
          push_v    = 1'b1;
          push_last = 1'b1;
          push_has  = pend_v_r;
          push_proc = pend_v_r ? GPROC_W'(pend_proc_r) : '0;
          push_safe = pend_v_r && (gcnt_r == np_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Step to the next process, or the next pass, or finish
    if (next_proc) begin
      state_nxt = S_PROC;
      if (last_proc) begin
        proc_nxt = '0;
        if (last_pass) state_nxt = S_FIN;
        else pass_nxt = pass_r + PCNT_W'(1);
      end else begin
        proc_nxt = proc_r + PROC_W'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      np_r        <= PCNT_W'(MAX_PROCESSES);
      nr_r        <= RCNT_W'(MAX_RESOURCES);
      pass_r      <= '0;
      proc_r      <= '0;
      res_r       <= '0;
      gcnt_r      <= '0;
      fin_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      np_r     <= np_nxt;
      nr_r     <= nr_nxt;
      pass_r   <= pass_nxt;
      proc_r   <= proc_nxt;
      res_r    <= res_nxt;
      gcnt_r   <= gcnt_nxt;
      fin_r    <= fin_nxt;
      pend_v_r <= pend_v_nxt;
      if (push_v) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_proc_r <= pend_proc_nxt;
    if (push_v) begin
      out_proc_r <= push_proc;
      out_has_r  <= push_has;
      out_safe_r <= push_safe;
      out_last_r <= push_last;
    end
  end

  // Working copy of the available vector
  always_ff @(posedge clk) begin
    if (state_r == S_INIT) begin
      for (int i = 0; i < MAX_RESOURCES; i++) begin
        work_r[i] <= WORK_W'(avail[i]);
      end
    end else if (work_we) begin
      work_r[res_r] <= alu.sum[WORK_W-1:0];
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.granted_process = out_proc_r;
  assign out_chan.has_process     = out_has_r;
  assign out_chan.is_safe         = out_safe_r;
  assign out_chan.last            = out_last_r;

`ifndef ASSERT_OFF
  // never more grants than processes in use while a check runs
  a_gcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE && state_r != S_INIT) |-> gcnt_r <= np_r)
    else $error("grant count exceeds process count");

  // a process is granted at most once per check
  a_no_regrant: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRANT && (!pend_v_r || slot_free)) |-> !fin_r[proc_r])
    else $error("process granted twice");

  // empty answer and safe flag appear only on the final result
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (!out_has_r || out_safe_r)) |-> out_last_r)
    else $error("empty or safe result not marked last");

  // a pending grant is never overwritten before it is pushed out
  a_pend_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_GRANT && pend_v_r && !slot_free) |=> $stable(pend_proc_r))
    else $error("pending grant lost");
`endif

endmodule

`default_nettype wire
